// ----- rtl/mp2d_pkg.sv -----
// Shared types, constants and helper functions of the 2-D max pooling stream block.
`timescale 1ns / 1ps

package mp2d_pkg;

   localparam int SAMPLE_W   = 16;              // signed Q8.8 sample
   localparam int MAXV_W     = SAMPLE_W - 1;    // clamped maximum, never negative
   localparam int COORD_W    = 10;              // coordinates and positions
   localparam int DIM_W      = 11;              // image and channel dimensions
   localparam int KER_W      = 4;               // kernel size registers
   localparam int OFF_W      = 3;               // offset inside a window
   localparam int MAX_KERNEL = 8;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_DIM    = 1024;
   localparam int WIN_W      = 2 * OFF_W + 1;   // found flag, row offset, column offset
   localparam int STORE_W    = WIN_W + MAXV_W;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int RECIP_W    = 15;
   localparam int RECIP_SH   = 14;
   localparam int RSP_DATA_W = 72;              // 65 payload bits rounded to bytes
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Register indexes (byte address / 4).
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_W      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KERNEL_H      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_W       = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_H       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

   typedef struct packed {
      logic [KER_W-1:0] kernel_w;
      logic [KER_W-1:0] kernel_h;
      logic [DIM_W-1:0] image_w;
      logic [DIM_W-1:0] image_h;
      logic [DIM_W-1:0] channel_count;
   } cfg_type;

   // Where the next sample falls and what it means for its window.
   typedef struct packed {
      logic               in_win;
      logic               win_first;
      logic               win_done;
      logic               last_win;
      logic [OFF_W-1:0]   kx;
      logic [OFF_W-1:0]   ky;
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
      logic [COORD_W-1:0] chan;
      logic [COORD_W-1:0] col_base;
      logic [COORD_W-1:0] row_base;
   } scan_type;

   function automatic logic [KER_W-1:0] clamp_kernel(input logic [KER_W-1:0] k);
      logic [KER_W-1:0] r;
      if (k == '0) begin
         r = KER_W'(1);
      end else if (k > KER_W'(MAX_KERNEL)) begin
         r = KER_W'(MAX_KERNEL);
      end else begin
         r = k;
      end
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = d;
      end
      return r;
   endfunction

   // ceil(2^14 / k); exact floor division for every value up to 2^14 / 3.
   function automatic logic [RECIP_W-1:0] recip(input logic [KER_W-1:0] k);
      logic [RECIP_W-1:0] r;
      unique case (k)
         4'd1:    r = 15'd16384;
         4'd2:    r = 15'd8192;
         4'd3:    r = 15'd5462;
         4'd4:    r = 15'd4096;
         4'd5:    r = 15'd3277;
         4'd6:    r = 15'd2731;
         4'd7:    r = 15'd2341;
         4'd8:    r = 15'd2048;
         default: r = 15'd2048;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/mp2d_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mp2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mp2d_scan.sv -----
// Raster position counters with window offsets, rebuilt after each register write.
`timescale 1ns / 1ps

module mp2d_scan import mp2d_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     cfg_wr,
   input  logic     step,
   output logic     busy,
   output scan_type scan
);

   localparam logic [1:0] SYNC_IDLE = 2'd0;
   localparam logic [1:0] SYNC_LOAD = 2'd1;
   localparam logic [1:0] SYNC_DIV  = 2'd2;

   logic [1:0]         sync_ff, sync_in;
   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in, chan_ff, chan_in;
   logic [OFF_W-1:0]   kx_ff, kx_in, ky_ff, ky_in;
   logic [COORD_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [COORD_W-1:0] qcol_ff, qcol_in, qrow_ff, qrow_in;
   logic [DIM_W-1:0]   ow_ff, ow_in, oh_ff, oh_in;

   logic [KER_W-1:0]   kw, kh;
   logic [DIM_W-1:0]   iw, ih, nc;
   logic [RECIP_W-1:0] rw, rh;
   logic [COORD_W+RECIP_W-1:0] pcol, prow;
   logic [DIM_W+RECIP_W-1:0]   pow, poh;
   logic [COORD_W+KER_W-1:0]   mcol, mrow;
   logic [COORD_W-1:0] rcol, rrow;
   logic [DIM_W-1:0]   col_nx, row_nx, chan_nx;

   always_comb begin
      kw = clamp_kernel(cfg.kernel_w);
      kh = clamp_kernel(cfg.kernel_h);
      iw = clamp_dim(cfg.image_w);
      ih = clamp_dim(cfg.image_h);
      nc = clamp_dim(cfg.channel_count);
      rw = recip(kw);
      rh = recip(kh);
      pcol = COORD_W'(col_ff) * rw;
      prow = COORD_W'(row_ff) * rh;
      pow  = iw * rw;
      poh  = ih * rh;
      mcol = qcol_ff * kw;
      mrow = qrow_ff * kh;
      rcol = col_ff - mcol[COORD_W-1:0];
      rrow = row_ff - mrow[COORD_W-1:0];
      col_nx  = {1'b0, col_ff} + DIM_W'(1);
      row_nx  = {1'b0, row_ff} + DIM_W'(1);
      chan_nx = {1'b0, chan_ff} + DIM_W'(1);
   end

   always_comb begin
      sync_in = sync_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      chan_in = chan_ff;
      kx_in   = kx_ff;
      ky_in   = ky_ff;
      ox_in   = ox_ff;
      oy_in   = oy_ff;
      qcol_in = qcol_ff;
      qrow_in = qrow_ff;
      ow_in   = ow_ff;
      oh_in   = oh_ff;

      unique case (sync_ff)
         SYNC_DIV: begin
            qcol_in = pcol[RECIP_SH +: COORD_W];
            qrow_in = prow[RECIP_SH +: COORD_W];
            ow_in   = pow[RECIP_SH +: DIM_W];
            oh_in   = poh[RECIP_SH +: DIM_W];
            sync_in = SYNC_LOAD;
         end
         SYNC_LOAD: begin
            ox_in   = qcol_ff;
            oy_in   = qrow_ff;
            kx_in   = rcol[OFF_W-1:0];
            ky_in   = rrow[OFF_W-1:0];
            sync_in = SYNC_IDLE;
         end
         SYNC_IDLE: begin
            if (step) begin
               if (col_nx >= iw) begin
                  col_in = '0;
                  kx_in  = '0;
                  ox_in  = '0;
                  if (row_nx >= ih) begin
                     row_in  = '0;
                     ky_in   = '0;
                     oy_in   = '0;
                     chan_in = (chan_nx >= nc) ? '0 : chan_nx[COORD_W-1:0];
                  end else begin
                     row_in = row_nx[COORD_W-1:0];
                     if (KER_W'({1'b0, ky_ff}) + KER_W'(1) == kh) begin
                        ky_in = '0;
                        oy_in = oy_ff + COORD_W'(1);
                     end else begin
                        ky_in = ky_ff + OFF_W'(1);
                     end
                  end
               end else begin
                  col_in = col_nx[COORD_W-1:0];
                  if (KER_W'({1'b0, kx_ff}) + KER_W'(1) == kw) begin
                     kx_in = '0;
                     ox_in = ox_ff + COORD_W'(1);
                  end else begin
                     kx_in = kx_ff + OFF_W'(1);
                  end
               end
            end
         end
         default: sync_in = SYNC_IDLE;
      endcase

      if (cfg_wr) begin
         sync_in = SYNC_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_DIV;
         col_ff  <= '0;
         row_ff  <= '0;
         chan_ff <= '0;
         kx_ff   <= '0;
         ky_ff   <= '0;
         ox_ff   <= '0;
         oy_ff   <= '0;
         qcol_ff <= '0;
         qrow_ff <= '0;
         ow_ff   <= '0;
         oh_ff   <= '0;
      end else begin
         sync_ff <= sync_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         chan_ff <= chan_in;
         kx_ff   <= kx_in;
         ky_ff   <= ky_in;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         qcol_ff <= qcol_in;
         qrow_ff <= qrow_in;
         ow_ff   <= ow_in;
         oh_ff   <= oh_in;
      end
   end

   assign busy = (sync_ff != SYNC_IDLE);

   always_comb begin
      scan.in_win    = ({1'b0, ox_ff} < ow_ff) && ({1'b0, oy_ff} < oh_ff);
      scan.win_first = (kx_ff == '0) && (ky_ff == '0);
      scan.win_done  = (KER_W'({1'b0, kx_ff}) + KER_W'(1) == kw) &&
                       (KER_W'({1'b0, ky_ff}) + KER_W'(1) == kh);
      scan.last_win  = ({1'b0, ox_ff} + DIM_W'(1) == ow_ff) &&
                       ({1'b0, oy_ff} + DIM_W'(1) == oh_ff) &&
                       (chan_nx == nc);
      scan.kx        = kx_ff;
      scan.ky        = ky_ff;
      scan.ox        = ox_ff;
      scan.oy        = oy_ff;
      scan.chan      = chan_ff;
      scan.col_base  = col_ff - COORD_W'(kx_ff);
      scan.row_base  = row_ff - COORD_W'(ky_ff);
   end

endmodule

// ----- rtl/max_pool_2d_stream_top.sv -----
// Top level of the streaming non-overlapping 2-D max pooling block.
`timescale 1ns / 1ps
// Throughput: one sample per cycle, sustained, as long as results are taken.
// A window's result reaches rsp_tvalid through the stage-1 request register
//   (row-store read at the accepting edge) and then the result register.
// After reset and after every register write, req_tready stays low while the
//   scan's divide and load states rebuild the window offsets from kept positions.
// Reset clears positions and control; the row store holds no reset value.

module max_pool_2d_stream_top import mp2d_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [15:0] sample
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [14:0] pooled_max, [24:15] out_x,
                                              // [34:25] out_y, [44:35] channel,
                                              // [54:45] winner_x, [64:55] winner_y,
                                              // [71:65] zero
   output logic                  rsp_tuser,   // [0] winner_found
   output logic                  rsp_tlast,   // final window of the tensor
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   cfg_type              cfg_ff, cfg_in;
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_KERNEL_W:      cfg_in.kernel_w      = csr_pwdata[KER_W-1:0];
            REG_KERNEL_H:      cfg_in.kernel_h      = csr_pwdata[KER_W-1:0];
            REG_IMAGE_W:       cfg_in.image_w       = csr_pwdata[DIM_W-1:0];
            REG_IMAGE_H:       cfg_in.image_h       = csr_pwdata[DIM_W-1:0];
            REG_CHANNEL_COUNT: cfg_in.channel_count = csr_pwdata[DIM_W-1:0];
            default:           cfg_in = cfg_ff;   // drop writes to unknown addresses
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_KERNEL_W:      csr_prdata = CSR_DATA_W'(cfg_ff.kernel_w);
         REG_KERNEL_H:      csr_prdata = CSR_DATA_W'(cfg_ff.kernel_h);
         REG_IMAGE_W:       csr_prdata = CSR_DATA_W'(cfg_ff.image_w);
         REG_IMAGE_H:       csr_prdata = CSR_DATA_W'(cfg_ff.image_h);
         REG_CHANNEL_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.channel_count);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_w      <= KER_W'(2);
         cfg_ff.kernel_h      <= KER_W'(2);
         cfg_ff.image_w       <= DIM_W'(1024);
         cfg_ff.image_h       <= DIM_W'(1024);
         cfg_ff.channel_count <= DIM_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Position tracking: tells where each accepted request lands in its window
   // ---------------------------------------------------------------------------
   scan_type scan;
   logic     scan_busy;
   logic     req_accept;

   mp2d_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cfg_wr (csr_wr),
      .step   (req_accept),
      .busy   (scan_busy),
      .scan   (scan)
   );

   // ---------------------------------------------------------------------------
   // Stage 1: request register. The row store is read at the accepting edge,
   // so its data lines up with the request held here.
   // ---------------------------------------------------------------------------
   logic                s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   scan_type            s1_ff;
   logic                s1_byp_ff, s1_byp_in;
   logic [MAXV_W-1:0]   byp_max_ff;
   logic [WIN_W-1:0]    byp_win_ff;
   logic                s1_emit, s1_adv, s1_wr;

   logic [STORE_W-1:0]  rd_data;
   logic [MAXV_W-1:0]   prev_max, new_max;
   logic [WIN_W-1:0]    prev_win, new_win;
   logic                take;
   logic                found;
   logic [COORD_W-1:0]  win_x, win_y;

   // A result-producing request may leave stage 1 only when the result register
   // is free or being emptied; other requests always move on.
   assign s1_emit    = s1_valid_ff && s1_ff.in_win && s1_ff.win_done;
   assign s1_adv     = !s1_emit || !rsp_tvalid || rsp_tready;
   assign s1_wr      = s1_valid_ff && s1_adv && s1_ff.in_win;
   assign req_tready = !scan_busy && (!s1_valid_ff || s1_adv);
   assign req_accept = req_tvalid && req_tready;

   // The store write of stage 1 and the read of the incoming request share an
   // edge; when they hit the same column, forward the freshly written entry.
   assign s1_byp_in   = req_accept && s1_wr && (scan.ox == s1_ff.ox);
   assign s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_comb begin
      if (s1_ff.win_first) begin
         prev_max = '0;
         prev_win = '0;
      end else if (s1_byp_ff) begin
         prev_max = byp_max_ff;
         prev_win = byp_win_ff;
      end else begin
         prev_max = rd_data[MAXV_W-1:0];
         prev_win = rd_data[STORE_W-1:MAXV_W];
      end
      // Non-negative sample at or above the running maximum wins; later wins ties.
      take    = !s1_sample_ff[SAMPLE_W-1] && (s1_sample_ff[MAXV_W-1:0] >= prev_max);
      new_max = take ? s1_sample_ff[MAXV_W-1:0] : prev_max;
      new_win = take ? {1'b1, s1_ff.ky, s1_ff.kx} : prev_win;
      found   = new_win[WIN_W-1];
      win_x   = found ? s1_ff.col_base + COORD_W'(new_win[OFF_W-1:0]) : '0;
      win_y   = found ? s1_ff.row_base + COORD_W'(new_win[2*OFF_W-1:OFF_W]) : '0;
   end

   mp2d_ram #(
      .WIDTH (STORE_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (s1_wr),
      .wr_addr (s1_ff.ox[ADDR_W-1:0]),
      .wr_data ({new_win, new_max}),
      .rd_en   (req_accept),
      .rd_addr (scan.ox[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_byp_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_accept) begin
            s1_byp_ff <= s1_byp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_tdata;
         s1_ff        <= scan;
         byp_max_ff   <= new_max;
         byp_win_ff   <= new_win;
      end
   end

   // ---------------------------------------------------------------------------
   // Result register: holds a finished window until the consumer takes it
   // ---------------------------------------------------------------------------
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_found_ff;
   logic                  rsp_last_ff;
   logic                  rsp_load;

   assign rsp_load     = s1_emit && s1_adv;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff  <= {7'b0, win_y, win_x, s1_ff.chan, s1_ff.oy, s1_ff.ox, new_max};
         rsp_found_ff <= found;
         rsp_last_ff  <= s1_ff.last_win;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- tb/max_pool_2d_stream_top_tb.sv -----
// Self-checking bench for the streaming 2-D max pooling block: predicts every window result.
`timescale 1ns / 1ps

module max_pool_2d_stream_top_tb;
   import mp2d_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int SAMPLE_BUDGET = 1750;
   localparam int IDLE_PCT      = 22;
   // The closing sample passes the stage-1 and result registers; leave margin on top.
   localparam int SETTLE_CYCLES = 6;
   // Keep one phase's worth of samples around this many, except the rare wide rows.
   localparam int PHASE_SAMPLES = 320;

   // One pooled window as it leaves the block.
   typedef struct packed {
      logic [MAXV_W-1:0]  peak;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [COORD_W-1:0] chan;
      logic [COORD_W-1:0] win_x;
      logic [COORD_W-1:0] win_y;
      logic               found;
      logic               tensor_end;
   } pooled_window_type;

   // Window predictor plus the queue of windows still owed by the block.
   class pool_scoreboard;
      logic [KER_W-1:0]   kernel_w_reg      = 4'd2;
      logic [KER_W-1:0]   kernel_h_reg      = 4'd2;
      logic [DIM_W-1:0]   image_w_reg       = 11'd1024;
      logic [DIM_W-1:0]   image_h_reg       = 11'd1024;
      logic [DIM_W-1:0]   channel_count_reg = 11'd1;
      int                 col_pos, row_pos, chan_pos;
      logic [MAXV_W-1:0]  peak_row [MAX_WIDTH];
      logic [WIN_W-1:0]   winner_row [MAX_WIDTH];
      pooled_window_type  pending_q [$];
      int                 errors;

      static function int clip(int v, int lo, int hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function int eff_kw();
         return clip(kernel_w_reg, 1, MAX_KERNEL);
      endfunction
      function int eff_kh();
         return clip(kernel_h_reg, 1, MAX_KERNEL);
      endfunction
      function int eff_iw();
         return clip(image_w_reg, 1, MAX_WIDTH);
      endfunction
      function int eff_ih();
         return clip(image_h_reg, 1, MAX_DIM);
      endfunction
      function int eff_nc();
         return clip(channel_count_reg, 1, MAX_DIM);
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_KERNEL_W:      kernel_w_reg      = val[KER_W-1:0];
            REG_KERNEL_H:      kernel_h_reg      = val[KER_W-1:0];
            REG_IMAGE_W:       image_w_reg       = val[DIM_W-1:0];
            REG_IMAGE_H:       image_h_reg       = val[DIM_W-1:0];
            REG_CHANNEL_COUNT: channel_count_reg = val[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      // True when the next row starts fresh windows under the given height,
      // so no row-store entry is read before it is written.
      function bit row_aligned(int kh_raw, int ih_raw);
         int kh = clip(kh_raw, 1, MAX_KERNEL);
         int ih = clip(ih_raw, 1, MAX_DIM);
         return (row_pos >= (ih / kh) * kh) || (row_pos % kh == 0);
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] s);
         int kw, kh, iw, ih, nc, ox, oy, kx, ky;
         logic [MAXV_W-1:0] m;
         logic [WIN_W-1:0]  w;
         pooled_window_type r;
         kw = eff_kw();
         kh = eff_kh();
         iw = eff_iw();
         ih = eff_ih();
         nc = eff_nc();
         if (col_pos < (iw / kw) * kw && row_pos < (ih / kh) * kh) begin
            ox = col_pos / kw;
            kx = col_pos % kw;
            oy = row_pos / kh;
            ky = row_pos % kh;
            if (kx == 0 && ky == 0) begin
               m = '0;
               w = '0;
            end else begin
               m = peak_row[ox];
               w = winner_row[ox];
            end
            // later samples win ties; negatives never beat the zero floor
            if (!s[SAMPLE_W-1] && s[MAXV_W-1:0] >= m) begin
               m = s[MAXV_W-1:0];
               w = {1'b1, OFF_W'(ky), OFF_W'(kx)};
            end
            peak_row[ox]   = m;
            winner_row[ox] = w;
            if (kx == kw - 1 && ky == kh - 1) begin
               r.peak       = m;
               r.out_x      = COORD_W'(ox);
               r.out_y      = COORD_W'(oy);
               r.chan       = COORD_W'(chan_pos);
               r.found      = w[WIN_W-1];
               r.win_x      = r.found ? COORD_W'(ox * kw + w[OFF_W-1:0]) : '0;
               r.win_y      = r.found ? COORD_W'(oy * kh + w[2*OFF_W-1:OFF_W]) : '0;
               r.tensor_end = (ox == iw / kw - 1) && (oy == ih / kh - 1) &&
                              (chan_pos == nc - 1);
               pending_q.push_back(r);
            end
         end
         if (col_pos + 1 >= iw) begin
            col_pos = 0;
            if (row_pos + 1 >= ih) begin
               row_pos  = 0;
               chan_pos = (chan_pos + 1 >= nc) ? 0 : chan_pos + 1;
            end else begin
               row_pos++;
            end
         end else begin
            col_pos++;
         end
      endfunction

      function void check_window(pooled_window_type got);
         pooled_window_type want;
         if (pending_q.size() == 0) begin
            if (errors < 10)
               $display("unexpected window: max=%0d out=(%0d,%0d) ch=%0d", got.peak,
                        got.out_x, got.out_y, got.chan);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (got.peak !== want.peak || got.out_x !== want.out_x ||
             got.out_y !== want.out_y || got.chan !== want.chan ||
             got.win_x !== want.win_x || got.win_y !== want.win_y ||
             got.found !== want.found || got.tensor_end !== want.tensor_end) begin
            if (errors < 10) begin
               $display("window mismatch, expected: max=%0d out=(%0d,%0d) ch=%0d",
                        want.peak, want.out_x, want.out_y, want.chan);
               $display("   win=(%0d,%0d) found=%0b end=%0b", want.win_x, want.win_y,
                        want.found, want.tensor_end);
               $display("  actual: max=%0d out=(%0d,%0d) ch=%0d", got.peak, got.out_x,
                        got.out_y, got.chan);
               $display("   win=(%0d,%0d) found=%0b end=%0b", got.win_x, got.win_y,
                        got.found, got.tensor_end);
            end
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pool_scoreboard sb;
   int             sent;
   int             wide_phases;
   bit             steady;       // high while both sides run without idling

   // Two channels of a 4x2 image under 2x2 windows, in raster order.
   // Channel 0: an all-negative window (no winner, includes the most negative
   // value and -1), then a window of ties that the last 5 must win.
   // Channel 1: largest positive value tied in the first window; once more among zeros.
   logic [SAMPLE_W-1:0] corner_set [16] = '{
      16'h8000, 16'hFFFF, 16'h0005, 16'h0005,
      16'hFFFF, 16'h8000, 16'h0005, 16'h0003,
      16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000,
      16'h0000, 16'h7FFF, 16'h0000, 16'h0000
   };

   max_pool_2d_stream_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (psel),
      .csr_penable (penable),
      .csr_pwrite  (pwrite),
      .csr_paddr   (paddr),
      .csr_pwdata  (pwdata),
      .csr_prdata  (prdata),
      .csr_pready  (pready)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Watch both channels at the rising edge. Everything read here holds its
   // pre-edge value, so a request and a result at the same edge are seen alike.
   always @(posedge clock) begin : monitor
      pooled_window_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         // note the request first: it may be the one that closes a window
         if (req_tvalid && req_tready)
            sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.peak       = rsp_tdata[14:0];
            got.out_x      = rsp_tdata[24:15];
            got.out_y      = rsp_tdata[34:25];
            got.chan       = rsp_tdata[44:35];
            got.win_x      = rsp_tdata[54:45];
            got.win_y      = rsp_tdata[64:55];
            got.found      = rsp_tuser;
            got.tensor_end = rsp_tlast;
            sb.check_window(got);
         end
         // stall the result side at random, except in the steady stretch
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Write one register: setup cycle, then access cycle until pready.
   // The predictor takes the value at once; writes only happen while idle.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      sb.write_reg(idx, val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_shape(input int kw, input int kh, input int iw, input int ih,
                            input int nc);
      csr_write(REG_KERNEL_W, kw);
      csr_write(REG_KERNEL_H, kh);
      csr_write(REG_IMAGE_W, iw);
      csr_write(REG_IMAGE_H, ih);
      csr_write(REG_CHANNEL_COUNT, nc);
   endtask

   // Offer one sample request, idling first at random, and hold it until taken.
   task automatic push_sample(input logic [SAMPLE_W-1:0] s);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      sent++;
      steady = (sent >= 600 && sent < 900);
   endtask

   // Drop valid and wait until every owed window has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_q.size() != 0);
   endtask

   // Drain, then let the pipeline settle before touching registers: a
   // trailing sample that closes no window may still be in flight.
   task automatic finish_phase();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sample styles: 0 anything, 1 tiny values around zero (ties, zero maxima),
   // 2 mostly negative (windows without a winner), 3 the range extremes.
   function automatic logic [SAMPLE_W-1:0] pick_sample(int style);
      logic [SAMPLE_W-1:0] s;
      s = SAMPLE_W'($urandom);
      case (style)
         1: s = SAMPLE_W'(int'($urandom_range(8)) - 4);
         2: if ($urandom_range(99) < 85) s[SAMPLE_W-1] = 1'b1;
         3: begin
            case ($urandom_range(5))
               0: s = {1'b0, {MAXV_W{1'b1}}};
               1: s = {1'b1, {MAXV_W{1'b0}}};
               2: s = '1;
               3: s = '0;
               4: s = SAMPLE_W'(1);
               default: ;
            endcase
         end
         default: ;
      endcase
      return s;
   endfunction

   // Kernel register values, a few of them outside the legal range.
   function automatic int pick_kernel();
      int r = $urandom_range(99);
      if (r < 4) return 0;
      if (r < 8) return $urandom_range(15, MAX_KERNEL + 1);
      return $urandom_range(MAX_KERNEL, 1);
   endfunction

   // Dimension register values: mostly small, rarely zero, the top or beyond.
   function automatic int pick_dim(int typical);
      int r = $urandom_range(99);
      if (r < 2) return 0;
      if (r < 4) return $urandom_range(2047, MAX_DIM + 1);
      if (r < 6) return MAX_DIM;
      return $urandom_range(typical, 1);
   endfunction

   initial begin
      int kw_v, kh_v, iw_v, ih_v, nc_v;
      int iw_e, ih_e, nc_e;
      int rows_left, rows, count, style;
      bit held_once;
      sb          = new;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      sent        = 0;
      wide_phases = 0;
      steady      = 1'b0;
      held_once   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: no-winner window, ties, extremes, last-window flag.
      set_shape(2, 2, 4, 2, 2);
      foreach (corner_set[i])
         push_sample(corner_set[i]);
      finish_phase();

      // Directed: out-of-range registers clamp; kernel wider than the image
      // means samples are only counted and nothing comes out.
      set_shape(MAX_KERNEL + 1, 0, 3, 2, 0);
      repeat (6)
         push_sample(pick_sample(3));
      finish_phase();

      // Random phases: new shape, then whole rows of samples. Each phase ends
      // on a row boundary, so a following write lands between rows.
      while (sent < SAMPLE_BUDGET) begin
         kw_v = pick_kernel();
         kh_v = pick_kernel();
         iw_v = pick_dim(48);
         ih_v = pick_dim(24);
         nc_v = pick_dim(4);
         iw_e = pool_scoreboard::clip(iw_v, 1, MAX_WIDTH);
         // allow only a couple of really wide rows, they eat the budget
         if (iw_e > 64) begin
            if (wide_phases >= 2 || sent + iw_e > SAMPLE_BUDGET) begin
               iw_v = $urandom_range(48, 1);
               iw_e = iw_v;
            end else begin
               wide_phases++;
            end
         end
         // a mid-tensor height change must not split a window row
         if (!sb.row_aligned(kh_v, ih_v))
            kh_v = 1;
         ih_e = pool_scoreboard::clip(ih_v, 1, MAX_DIM);
         nc_e = pool_scoreboard::clip(nc_v, 1, MAX_DIM);
         set_shape(kw_v, kh_v, iw_v, ih_v, nc_v);

         // finish the tensor when it is small, else send a budget of rows
         rows_left = ((sb.row_pos < ih_e) ? ih_e - sb.row_pos : 1) +
                     ih_e * ((sb.chan_pos < nc_e) ? nc_e - 1 - sb.chan_pos : 0);
         if (rows_left * iw_e <= PHASE_SAMPLES)
            rows = rows_left;
         else
            rows = $urandom_range((PHASE_SAMPLES / iw_e > 1) ? PHASE_SAMPLES / iw_e : 1, 1);
         count = rows * iw_e;
         style = $urandom_range(3);
         for (int i = 0; i < count; i++) begin
            // once, hold the sender mid-phase until every window is back
            if (!held_once && i > 0 && i == count / 2) begin
               drain_results();
               held_once = 1'b1;
            end
            push_sample(pick_sample(style));
         end
         finish_phase();
      end

      drain_results();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this.
   initial begin
      #(64'd10_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mp2d_pkg.sv
rtl/mp2d_ram.sv
rtl/mp2d_scan.sv
rtl/max_pool_2d_stream_top.sv
tb/max_pool_2d_stream_top_tb.sv
